// ===== rtl/core/fair_round_robin_aggregator_unit_macros.svh =====
// Assertion macros for the round-robin aggregator.
`ifndef FAIR_ROUND_ROBIN_AGGREGATOR_UNIT_MACROS_SVH
`define FAIR_ROUND_ROBIN_AGGREGATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FRRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frra assertion failed");
`define FRRA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frra reset assertion failed");
`else
`define FRRA_ASSERT(lbl, prop)
`define FRRA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/frra_pkg.sv =====
// Package with types and constants of the round-robin aggregator.
`default_nettype none
package frra_pkg;
  localparam int MAX_SOURCES = 16;
  localparam int ID_W = 4;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_ATTACH = 3'd0;
  localparam logic [OP_W-1:0] OP_DETACH = 3'd1;
  localparam logic [OP_W-1:0] OP_DEACTIVATE = 3'd2;
  localparam logic [OP_W-1:0] OP_REACTIVATE = 3'd3;
  localparam logic [OP_W-1:0] OP_RECEIVE = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] source_id;
    logic [15:0] ready_mask;
  } in_word_t;

  typedef struct packed {
    logic granted;
    logic [ID_W-1:0] grant_source;
    logic [CNT_W-1:0] active_count;
    logic [CNT_W-1:0] attached_count;
    logic wake;
    logic op_error;
  } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/core/fair_round_robin_aggregator_unit.sv =====
// Round-robin aggregator over an active set of attached sources.
//
// One input word carries an operation (attach, detach, deactivate,
// reactivate or receive) and one output word reports its outcome, with the
// grant of a receive and the counts after the operation. Both channels use
// valid and ready. The block takes one word at a time through a small
// sequencer; in_ready is high only while it waits for the next word.
// A slot swap reads both slots and then writes both, since each table has
// one read and one write port. Attach, deactivate and reactivate need at
// most one swap and detach up to two. A receive tries the active slots in
// turn and, on its first step, wraps a stale pointer by repeated
// subtraction in the compare and subtract state.
// A finished word sits in an output register, so the next word can be
// accepted while it waits; a stalled receiver holds the block in its final
// state only when a second result is ready before the first is taken.
// Reset empties the source set, clears the pointer and drops out_valid.
// The slot tables are not cleared; only their attached entries are read.
`default_nettype none
`include "fair_round_robin_aggregator_unit_macros.svh"
module fair_round_robin_aggregator_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire frra_pkg::in_word_t in_word,
  output logic out_valid,
  input  wire logic out_ready,
  output frra_pkg::out_word_t out_word
);
  import frra_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EXEC = 4'd1;
  localparam logic [3:0] ST_SW_RA = 4'd2;
  localparam logic [3:0] ST_SW_RB = 4'd3;
  localparam logic [3:0] ST_SW_WA = 4'd4;
  localparam logic [3:0] ST_SW_WB = 4'd5;
  localparam logic [3:0] ST_DT2 = 4'd6;
  localparam logic [3:0] ST_SC_STEP = 4'd7;
  localparam logic [3:0] ST_SC_MOD = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [OP_W-1:0] op_r;
  logic [ID_W-1:0] src_r;
  logic [15:0] ready_r;
  logic [ID_W-1:0] tab_r [MAX_SOURCES];
  logic [SLOT_W-1:0] sos_r [16];
  logic [15:0] att_bits_r, att_bits_nxt;
  logic [CNT_W-1:0] att_tot_r, att_tot_nxt, act_tot_r, act_tot_nxt;
  logic [SLOT_W-1:0] rr_r, rr_nxt;
  logic start_r, start_nxt;
  logic [SLOT_W-1:0] sw_a_r, sw_a_nxt, sw_b_r, sw_b_nxt, a2_r, a2_nxt;
  logic [ID_W-1:0] ta_r, ta_nxt, tb_r, tb_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, v_r, v_nxt;
  logic gr_r, gr_nxt, wake_r, wake_nxt, err_r, err_nxt;
  logic [ID_W-1:0] gsrc_r, gsrc_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic [SLOT_W-1:0] tab_raddr;
  logic [ID_W-1:0] tab_rdata;
  logic [SLOT_W-1:0] sos_rdata;
  logic tab_we, sos_we;
  logic [SLOT_W-1:0] tab_waddr;
  logic [ID_W-1:0] tab_wdata;
  logic [ID_W-1:0] sos_waddr;
  logic [SLOT_W-1:0] sos_wdata;
  logic src_att, src_act;
  logic [CNT_W-1:0] act_dec;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  assign tab_rdata = tab_r[tab_raddr];
  assign sos_rdata = sos_r[src_r];
  assign src_att = att_bits_r[src_r];
  assign src_act = src_att && ({1'b0, sos_rdata} < act_tot_r);
  assign act_dec = act_tot_r - 5'd1;

  always_comb begin
    unique case (state_r)
      ST_SW_RB: tab_raddr = sw_b_r;
      ST_SC_MOD: tab_raddr = v_r[SLOT_W-1:0];
      default: tab_raddr = sw_a_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    att_bits_nxt = att_bits_r;
    att_tot_nxt = att_tot_r;
    act_tot_nxt = act_tot_r;
    rr_nxt = rr_r;
    start_nxt = start_r;
    sw_a_nxt = sw_a_r;
    sw_b_nxt = sw_b_r;
    a2_nxt = a2_r;
    ta_nxt = ta_r;
    tb_nxt = tb_r;
    cnt_nxt = cnt_r;
    v_nxt = v_r;
    gr_nxt = gr_r;
    gsrc_nxt = gsrc_r;
    wake_nxt = wake_r;
    err_nxt = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt = out_word_r;
    tab_we = 1'b0;
    tab_waddr = sw_a_r;
    tab_wdata = tb_r;
    sos_we = 1'b0;
    sos_waddr = tb_r;
    sos_wdata = sw_a_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        gr_nxt = 1'b0;
        gsrc_nxt = '0;
        wake_nxt = 1'b0;
        err_nxt = 1'b0;
        state_nxt = ST_DONE;
        ret_nxt = ST_DONE;
        unique case (op_r)
          OP_ATTACH: begin
            if (src_att || (att_tot_r >= CNT_W'(MAX_SOURCES))) begin
              err_nxt = 1'b1;
            end else begin
              tab_we = 1'b1;
              tab_waddr = att_tot_r[SLOT_W-1:0];
              tab_wdata = src_r;
              sos_we = 1'b1;
              sos_waddr = src_r;
              sos_wdata = att_tot_r[SLOT_W-1:0];
              att_bits_nxt[src_r] = 1'b1;
              att_tot_nxt = att_tot_r + 5'd1;
              act_tot_nxt = act_tot_r + 5'd1;
              wake_nxt = (act_tot_r == '0);
              if (att_tot_r != act_tot_r) begin
                sw_a_nxt = att_tot_r[SLOT_W-1:0];
                sw_b_nxt = act_tot_r[SLOT_W-1:0];
                state_nxt = ST_SW_RA;
              end
            end
          end
          OP_DETACH, OP_DEACTIVATE: begin
            if (!src_att || ((op_r == OP_DEACTIVATE) && !src_act)) begin
              err_nxt = 1'b1;
            end else begin
              state_nxt = ST_SW_RA;
              if (src_act) begin
                sw_a_nxt = sos_rdata;
                sw_b_nxt = act_dec[SLOT_W-1:0];
                a2_nxt = act_dec[SLOT_W-1:0];
                act_tot_nxt = act_dec;
                if (act_dec == '0) begin
                  start_nxt = 1'b1;
                  rr_nxt = '0;
                end else if (sos_rdata == rr_r) begin
                  rr_nxt = (sos_rdata == '0) ? SLOT_W'(act_dec - 5'd1)
                                             : sos_rdata - 4'd1;
                end
                if (op_r == OP_DETACH) begin
                  ret_nxt = ST_DT2;
                end
              end else begin
                sw_a_nxt = sos_rdata;
                sw_b_nxt = SLOT_W'(att_tot_r - 5'd1);
              end
              if (op_r == OP_DETACH) begin
                att_tot_nxt = att_tot_r - 5'd1;
                att_bits_nxt[src_r] = 1'b0;
              end
            end
          end
          OP_REACTIVATE: begin
            if (!src_att || src_act) begin
              err_nxt = 1'b1;
            end else begin
              sw_a_nxt = sos_rdata;
              sw_b_nxt = act_tot_r[SLOT_W-1:0];
              act_tot_nxt = act_tot_r + 5'd1;
              wake_nxt = (act_tot_r == '0);
              state_nxt = ST_SW_RA;
            end
          end
          OP_RECEIVE: begin
            cnt_nxt = act_tot_r;
            if (act_tot_r != '0) begin
              state_nxt = ST_SC_STEP;
            end
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
      ST_SW_RA: begin
        ta_nxt = tab_rdata;
        state_nxt = ST_SW_RB;
      end
      ST_SW_RB: begin
        tb_nxt = tab_rdata;
        tab_we = 1'b1;
        tab_waddr = sw_b_r;
        tab_wdata = ta_r;
        state_nxt = ST_SW_WA;
      end
      ST_SW_WA: begin
        tab_we = 1'b1;
        sos_we = 1'b1;
        state_nxt = ST_SW_WB;
      end
      ST_SW_WB: begin
        sos_we = 1'b1;
        sos_waddr = ta_r;
        sos_wdata = sw_b_r;
        state_nxt = ret_r;
      end
      ST_DT2: begin
        sw_a_nxt = a2_r;
        sw_b_nxt = att_tot_r[SLOT_W-1:0];
        ret_nxt = ST_DONE;
        state_nxt = ST_SW_RA;
      end
      ST_SC_STEP: begin
        if (start_r) begin
          v_nxt = '0;
          start_nxt = 1'b0;
        end else begin
          v_nxt = {1'b0, rr_r} + 5'd1;
        end
        state_nxt = ST_SC_MOD;
      end
      ST_SC_MOD: begin
        if (v_r >= act_tot_r) begin
          v_nxt = v_r - act_tot_r;
        end else begin
          rr_nxt = v_r[SLOT_W-1:0];
          if (ready_r[tab_rdata]) begin
            gr_nxt = 1'b1;
            gsrc_nxt = tab_rdata;
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt = cnt_r - 5'd1;
            state_nxt = (cnt_r == 5'd1) ? ST_DONE : ST_SC_STEP;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt.granted = gr_r;
          out_word_nxt.grant_source = gsrc_r;
          out_word_nxt.active_count = act_tot_r;
          out_word_nxt.attached_count = att_tot_r;
          out_word_nxt.wake = wake_r;
          out_word_nxt.op_error = err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_r[tab_waddr] <= tab_wdata;
    end
    if (sos_we) begin
      sos_r[sos_waddr] <= sos_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      att_bits_r <= '0;
      att_tot_r <= '0;
      act_tot_r <= '0;
      rr_r <= '0;
      start_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      att_bits_r <= att_bits_nxt;
      att_tot_r <= att_tot_nxt;
      act_tot_r <= act_tot_nxt;
      rr_r <= rr_nxt;
      start_r <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_word.opcode;
      src_r <= in_word.source_id;
      ready_r <= in_word.ready_mask;
    end
    ret_r <= ret_nxt;
    sw_a_r <= sw_a_nxt;
    sw_b_r <= sw_b_nxt;
    a2_r <= a2_nxt;
    ta_r <= ta_nxt;
    tb_r <= tb_nxt;
    cnt_r <= cnt_nxt;
    v_r <= v_nxt;
    gr_r <= gr_nxt;
    gsrc_r <= gsrc_nxt;
    wake_r <= wake_nxt;
    err_r <= err_nxt;
    out_word_r <= out_word_nxt;
  end

  `FRRA_ASSERT(a_active_le_attached, act_tot_r <= att_tot_r)
  `FRRA_ASSERT(a_attached_popcount, $countones(att_bits_r) == 32'(att_tot_r))
  `FRRA_ASSERT(a_accept_starts_exec, (in_valid && in_ready) |=> (state_r == ST_EXEC))
  `FRRA_ASSERT(a_scan_bounded, (state_r == ST_SC_STEP) |-> (cnt_r != '0 && cnt_r <= act_tot_r))
  `FRRA_ASSERT_RST(a_reset_empty, !rst_n |=> (att_tot_r == '0 && !out_valid_r))
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the round-robin aggregator over an active set of sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import frra_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_OPS = 530;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  in_word_t op_q[$];
  out_word_t outcome_q[$];
  int failures = 0;
  int stall_cycles = 0;
  int send_wait = 0;
  int send_calm = 0;
  int take_wait = 0;
  int take_calm = 0;

  // Shadow of the aggregator's slot tables and pointer.
  logic [3:0] slot_src [MAX_SOURCES];
  int src_slot [16];
  logic [15:0] attached = '0;
  int n_attached = 0;
  int n_active = 0;
  int rr_ptr = 0;
  logic restart_at_zero = 1'b1;

  // Membership as seen by the stimulus generator, used to bias it toward legal operations.
  logic [15:0] gen_attached = '0;
  logic [15:0] gen_active = '0;

  fair_round_robin_aggregator_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void swap_slots(int a, int b);
    logic [3:0] t;
    t = slot_src[a];
    slot_src[a] = slot_src[b];
    slot_src[b] = t;
    src_slot[slot_src[a]] = a;
    src_slot[slot_src[b]] = b;
  endfunction

  function automatic logic is_active(int s);
    return attached[s] && src_slot[s] < n_active;
  endfunction

  function automatic void make_idle(int s);
    int idx;
    idx = src_slot[s];
    swap_slots(idx, n_active - 1);
    n_active--;
    if (n_active == 0) begin
      restart_at_zero = 1'b1;
      rr_ptr = 0;
    end else if (idx == rr_ptr) begin
      rr_ptr = (idx == 0) ? n_active - 1 : idx - 1;
    end
  endfunction

  function automatic out_word_t next_outcome(in_word_t w);
    out_word_t r;
    int s;
    int i;
    logic [3:0] src;
    r = '0;
    s = w.source_id;
    case (w.opcode)
      OP_ATTACH: begin
        if (attached[s] || n_attached >= MAX_SOURCES) begin
          r.op_error = 1'b1;
        end else begin
          slot_src[n_attached] = 4'(s);
          src_slot[s] = n_attached;
          attached[s] = 1'b1;
          n_attached++;
          n_active++;
          if (n_attached > n_active) swap_slots(n_attached - 1, n_active - 1);
          if (n_active == 1) r.wake = 1'b1;
        end
      end
      OP_DETACH: begin
        if (!attached[s]) begin
          r.op_error = 1'b1;
        end else begin
          if (is_active(s)) make_idle(s);
          swap_slots(src_slot[s], n_attached - 1);
          n_attached--;
          attached[s] = 1'b0;
        end
      end
      OP_DEACTIVATE: begin
        if (!is_active(s)) r.op_error = 1'b1;
        else make_idle(s);
      end
      OP_REACTIVATE: begin
        if (!attached[s] || is_active(s)) begin
          r.op_error = 1'b1;
        end else begin
          swap_slots(src_slot[s], n_active);
          n_active++;
          if (n_active == 1) r.wake = 1'b1;
        end
      end
      OP_RECEIVE: begin
        for (i = 0; i < n_active && !r.granted; i++) begin
          if (restart_at_zero) begin
            rr_ptr = 0;
            restart_at_zero = 1'b0;
          end else begin
            rr_ptr = (rr_ptr + 1) % n_active;
          end
          src = slot_src[rr_ptr];
          if (w.ready_mask[src]) begin
            r.granted = 1'b1;
            r.grant_source = src;
          end
        end
      end
      default: r.op_error = 1'b1;
    endcase
    r.active_count = CNT_W'(n_active);
    r.attached_count = CNT_W'(n_attached);
    return r;
  endfunction

  function automatic logic [3:0] pick_member(logic [15:0] m);
    int k;
    int i;
    if (m == '0) return 4'($urandom_range(0, 15));
    k = $urandom_range(0, $countones(m) - 1);
    for (i = 0; i < 16; i++) begin
      if (m[i]) begin
        if (k == 0) return 4'(i);
        k--;
      end
    end
    return 4'd0;
  endfunction

  function automatic void add_op(logic [OP_W-1:0] op, logic [3:0] src, logic [15:0] mask);
    in_word_t w;
    w.opcode = op;
    w.source_id = src;
    w.ready_mask = mask;
    op_q.insert(op_q.size(), w);
    case (op)
      OP_ATTACH: begin
        if (!gen_attached[src]) begin
          gen_attached[src] = 1'b1;
          gen_active[src] = 1'b1;
        end
      end
      OP_DETACH: begin
        gen_attached[src] = 1'b0;
        gen_active[src] = 1'b0;
      end
      OP_DEACTIVATE: gen_active[src] = 1'b0;
      OP_REACTIVATE: if (gen_attached[src]) gen_active[src] = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      failures++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  initial begin
    int n;
    int k;
    int target;
    int roll;
    logic [OP_W-1:0] op;
    logic [3:0] src;
    logic [15:0] mask;

    add_op(OP_RECEIVE, 4'd0, 16'hFFFF);
    add_op(OP_DETACH, 4'd0, 16'h0000);
    add_op(OP_DEACTIVATE, 4'd15, 16'hFFFF);
    add_op(OP_REACTIVATE, 4'd15, 16'h0000);
    add_op(OP_ATTACH, 4'd0, 16'h0000);
    add_op(OP_ATTACH, 4'd0, 16'hFFFF);
    add_op(OP_ATTACH, 4'd15, 16'h0000);
    add_op(OP_ATTACH, 4'd7, 16'h0000);
    add_op(OP_RECEIVE, 4'd0, 16'hFFFF);
    add_op(OP_RECEIVE, 4'd15, 16'h0000);
    add_op(OP_RECEIVE, 4'd0, 16'h8000);
    add_op(OP_DEACTIVATE, 4'd15, 16'h0000);
    add_op(OP_DEACTIVATE, 4'd15, 16'h0000);
    add_op(OP_REACTIVATE, 4'd0, 16'h0000);
    add_op(OP_RECEIVE, 4'd0, 16'h0001);
    add_op(OP_DEACTIVATE, 4'd0, 16'h0000);
    add_op(OP_DETACH, 4'd15, 16'h0000);
    add_op(OP_DEACTIVATE, 4'd7, 16'h0000);
    add_op(OP_RECEIVE, 4'd0, 16'hFFFF);
    add_op(OP_REACTIVATE, 4'd7, 16'h0000);
    add_op(OP_RECEIVE, 4'd0, 16'hFFFF);
    add_op(OP_DETACH, 4'd7, 16'h0000);
    for (k = 1; k <= 3; k++) add_op(OP_RECEIVE + OP_W'(k), 4'd15, 16'hFFFF);

    target = 0;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) target = $urandom_range(0, 16);
      roll = $urandom_range(0, 99);
      mask = 16'($urandom());
      if (roll < 4) begin
        op = OP_RECEIVE + OP_W'($urandom_range(1, 3));
      end else if (roll < 40) begin
        op = OP_RECEIVE;
      end else if ($countones(gen_attached) < target && $urandom_range(0, 99) < 60) begin
        op = OP_ATTACH;
      end else if ($countones(gen_attached) > target && $urandom_range(0, 99) < 40) begin
        op = OP_DETACH;
      end else begin
        case ($urandom_range(0, 3))
          0: op = OP_ATTACH;
          1: op = OP_DETACH;
          2: op = OP_DEACTIVATE;
          default: op = OP_REACTIVATE;
        endcase
      end
      src = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 88) begin
        case (op)
          OP_ATTACH: src = pick_member(~gen_attached);
          OP_DETACH: src = pick_member(gen_attached);
          OP_DEACTIVATE: src = pick_member(gen_active);
          OP_REACTIVATE: src = pick_member(gen_attached & ~gen_active);
          default: ;
        endcase
      end
      if (op == OP_RECEIVE) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) mask = 16'h0001 << $urandom_range(0, 15);
        else if (roll < 40) mask = 16'h0000;
        else if (roll < 50) mask = 16'hFFFF;
        else if (roll < 75) mask = 16'($urandom() & $urandom() & $urandom());
      end
      add_op(op, src, mask);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_q.size() != 0 || in_valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, outcome_q.size());
    end
    if (failures == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        outcome_q.insert(outcome_q.size(), next_outcome(in_word));
        nxt_valid = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_wait = 0;
        end else begin
          send_wait = $urandom_range(0, 17);
          if ($urandom_range(0, 99) < 6) send_calm = $urandom_range(10, 40);
        end
      end
      if (!nxt_valid && op_q.size() > 0) begin
        if (send_wait > 0) begin
          send_wait--;
        end else begin
          in_word <= op_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    logic nxt_ready;
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          failures++;
          $display("%0t: result with none expected, got %h", $time, out_word);
        end else begin
          want = outcome_q.pop_front();
          check_field("granted", int'(want.granted), int'(out_word.granted));
          check_field("grant_source", int'(want.grant_source),
                      int'(out_word.grant_source));
          check_field("active_count", int'(want.active_count),
                      int'(out_word.active_count));
          check_field("attached_count", int'(want.attached_count),
                      int'(out_word.attached_count));
          check_field("wake", int'(want.wake), int'(out_word.wake));
          check_field("op_error", int'(want.op_error), int'(out_word.op_error));
        end
        nxt_ready = 1'b0;
        if (take_calm > 0) begin
          take_calm--;
          take_wait = 0;
        end else begin
          take_wait = $urandom_range(0, 17);
          if ($urandom_range(0, 99) < 6) take_calm = $urandom_range(10, 40);
        end
      end
      if (!nxt_ready) begin
        if (take_wait > 0) take_wait--;
        else nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end
endmodule
